// ===== src/hhlp_pkg.sv =====
// Shared types, character codes and name table for the HTTP header length parser.
`default_nettype none

package hhlp_pkg;

	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [3:0]  NAME_LEN       = 4'd14;
	localparam logic [30:0] DEFAULT_LENGTH = 31'd4;

	typedef enum logic [2:0] {
		ROLE_NAME    = 3'd0,
		ROLE_COLON   = 3'd1,
		ROLE_VALUE   = 3'd2,
		ROLE_LF      = 3'd3,
		ROLE_IGNORED = 3'd4
	} role_t;

	typedef enum logic [1:0] {
		LS_START       = 2'd0,
		LS_CR_ONLY     = 2'd1,
		LS_NAME        = 2'd2,
		LS_COLON_FIRST = 2'd3
	} line_state_t;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       new_message;
	} hhlp_in_t;

	typedef struct packed {
		role_t              byte_role;
		logic               line_done;
		logic               header_end;
		logic signed [31:0] content_length;
	} hhlp_out_t;

	// Expected character of the header name at a given position.
	function automatic logic [7:0] name_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = "C";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "L";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== src/http_header_length_parser_unit.sv =====
// Top level of the HTTP response header parser that tracks Content-Length.
`default_nettype none

// Usage:
//   in channel  (in_valid / in_ready / in_data): one response byte per word,
//     with new_message set on the first byte of a fresh response to drop all
//     parse state before that byte is taken.
//   out channel (out_valid / out_ready / out_data): exactly one word per input
//     word, in order: the role of the byte, line and header-end flags, and the
//     content length seen so far (default substituted while it is zero).
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes default_length;
//     always ready, write only while no byte is in flight.
// Pipeline: a byte is captured in the input register; when the output
//   register can take a word, the byte is classified, folded into the parse
//   state and its result loaded into the output register at the same edge.
// Throughput: one byte per clock while the receiver keeps out_ready high.
//   The longest path is the decimal accumulate (times ten plus digit, then
//   saturate) feeding the line value register.
// Reset: parse state clears, default_length returns to 4, both pipeline
//   registers empty. When the receiver stalls, the output word holds, the
//   input register fills behind it and in_ready drops; nothing is lost.
module http_header_length_parser_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire hhlp_pkg::hhlp_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output hhlp_pkg::hhlp_out_t    out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [30:0]       cfg_data
);
	import hhlp_pkg::*;

	// Pipeline registers
	logic      valid_s1;
	hhlp_in_t  in_s1;
	logic      valid_s2;
	hhlp_out_t out_s2;

	// Configuration
	logic [30:0] default_length_q;

	// Parse state
	logic        in_value_q;
	logic        prev_cr_q;
	line_state_t line_start_q;
	logic [3:0]  match_pos_q;
	logic        match_fail_q;
	phase_t      phase_q;
	logic        negative_q;
	logic [31:0] line_value_q;
	logic [31:0] length_q;
	logic        hdr_done_q;

	// State as seen by the current byte, after an optional message clear
	logic        in_value_e;
	logic        prev_cr_e;
	line_state_t line_start_e;
	logic [3:0]  match_pos_e;
	logic        match_fail_e;
	phase_t      phase_e;
	logic        negative_e;
	logic [31:0] line_value_e;
	logic [31:0] length_e;
	logic        hdr_done_e;

	// Next state
	logic        in_value_n;
	logic        prev_cr_n;
	line_state_t line_start_n;
	logic [3:0]  match_pos_n;
	logic        match_fail_n;
	phase_t      phase_n;
	logic        negative_n;
	logic [31:0] line_value_n;
	logic [31:0] length_n;
	logic        hdr_done_n;

	logic        advance_s2;
	logic        advance_s1;
	logic [7:0]  b;
	logic        is_digit;
	logic        is_white;
	logic [35:0] times_ten;
	logic [35:0] accum;
	logic [31:0] accum_sat;
	logic [31:0] line_result;
	line_state_t ls_tmp;
	hhlp_out_t   result;

	// Handshake: the output register frees when empty or taken; the input
	// register moves on whenever the output register can take its result.
	assign advance_s2 = !valid_s2 || out_ready;
	assign advance_s1 = valid_s1 && advance_s2;
	assign in_ready   = !valid_s1 || advance_s2;
	assign out_valid  = valid_s2;
	assign out_data   = out_s2;
	assign cfg_ready  = 1'b1;

	assign b        = in_s1.data_byte;
	assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	assign is_white = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));

	// A fresh message drops everything but the configuration.
	always_comb begin
		if (in_s1.new_message) begin
			in_value_e   = 1'b0;
			prev_cr_e    = 1'b0;
			line_start_e = LS_START;
			match_pos_e  = 4'd0;
			match_fail_e = 1'b0;
			phase_e      = PH_SKIP;
			negative_e   = 1'b0;
			line_value_e = 32'd0;
			length_e     = 32'd0;
			hdr_done_e   = 1'b0;
		end else begin
			in_value_e   = in_value_q;
			prev_cr_e    = prev_cr_q;
			line_start_e = line_start_q;
			match_pos_e  = match_pos_q;
			match_fail_e = match_fail_q;
			phase_e      = phase_q;
			negative_e   = negative_q;
			line_value_e = line_value_q;
			length_e     = length_q;
			hdr_done_e   = hdr_done_q;
		end
	end

	// Decimal accumulate: magnitude * 10 + digit, saturated at 2^31.
	assign times_ten = ({4'd0, line_value_e} << 3) + ({4'd0, line_value_e} << 1);
	assign accum     = times_ten + {28'd0, b - CHAR_ZERO};
	assign accum_sat = (accum > 36'h0_8000_0000) ? 32'h8000_0000 : accum[31:0];

	// Signed value of the finished line, clamped on the positive side.
	always_comb begin
		if (!in_value_e) begin
			line_result = 32'd0;
		end else if (negative_e) begin
			line_result = 32'd0 - line_value_e;
		end else if (line_value_e > 32'h7fff_ffff) begin
			line_result = 32'h7fff_ffff;
		end else begin
			line_result = line_value_e;
		end
	end

	// Classify the byte and compute the next parse state.
	always_comb begin
		in_value_n   = in_value_e;
		prev_cr_n    = prev_cr_e;
		line_start_n = line_start_e;
		match_pos_n  = match_pos_e;
		match_fail_n = match_fail_e;
		phase_n      = phase_e;
		negative_n   = negative_e;
		line_value_n = line_value_e;
		length_n     = length_e;
		hdr_done_n   = hdr_done_e;
		ls_tmp       = line_start_e;
		result.byte_role  = ROLE_IGNORED;
		result.line_done  = 1'b0;
		result.header_end = 1'b0;

		if (hdr_done_e) begin
			result.byte_role = ROLE_IGNORED;
		end else if ((b == CHAR_LF) && prev_cr_e) begin
			result.byte_role = ROLE_LF;
			result.line_done = 1'b1;
			if (in_value_e ? (line_start_e == LS_COLON_FIRST)
				: (line_start_e == LS_CR_ONLY)) begin
				hdr_done_n        = 1'b1;
				result.header_end = 1'b1;
			end else if (!match_fail_e && (match_pos_e == NAME_LEN)) begin
				length_n = line_result;
			end
			in_value_n   = 1'b0;
			line_start_n = LS_START;
			match_pos_n  = 4'd0;
			match_fail_n = 1'b0;
			phase_n      = PH_SKIP;
			negative_n   = 1'b0;
			line_value_n = 32'd0;
			prev_cr_n    = 1'b0;
		end else if (!in_value_e) begin
			// A CR not followed by LF spoils the name match.
			if (prev_cr_e) begin
				match_fail_n = 1'b1;
			end
			if (line_start_e == LS_CR_ONLY) begin
				ls_tmp = LS_NAME;
			end
			if (b == CHAR_COLON) begin
				result.byte_role = ROLE_COLON;
				in_value_n       = 1'b1;
				line_start_n     = (ls_tmp == LS_START) ? LS_COLON_FIRST : LS_NAME;
			end else begin
				result.byte_role = ROLE_NAME;
				if (ls_tmp == LS_START) begin
					line_start_n = (b == CHAR_CR) ? LS_CR_ONLY : LS_NAME;
				end else begin
					line_start_n = ls_tmp;
				end
				if (b != CHAR_CR) begin
					if (!match_fail_n && (match_pos_e < NAME_LEN)
						&& (b == name_char(match_pos_e))) begin
						match_pos_n = match_pos_e + 4'd1;
					end else begin
						match_fail_n = 1'b1;
					end
				end
			end
			prev_cr_n = (b == CHAR_CR);
		end else begin
			result.byte_role = ROLE_VALUE;
			case (phase_e)
				PH_SKIP: begin
					if (is_white) begin
						phase_n = PH_SKIP;
					end else if ((b == CHAR_PLUS) || (b == CHAR_MINUS)) begin
						negative_n = (b == CHAR_MINUS);
						phase_n    = PH_SIGN;
					end else if (is_digit) begin
						line_value_n = accum_sat;
						phase_n      = PH_DIGITS;
					end else begin
						phase_n = PH_DONE;
					end
				end
				PH_SIGN, PH_DIGITS: begin
					if (is_digit) begin
						line_value_n = accum_sat;
						phase_n      = PH_DIGITS;
					end else begin
						phase_n = PH_DONE;
					end
				end
				default: begin
					phase_n = phase_e;
				end
			endcase
			prev_cr_n = (b == CHAR_CR);
		end

		result.content_length = (length_n == 32'd0) ? {1'b0, default_length_q} : length_n;
	end

	// Control and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			default_length_q <= DEFAULT_LENGTH;
			in_value_q       <= 1'b0;
			prev_cr_q        <= 1'b0;
			line_start_q     <= LS_START;
			match_pos_q      <= 4'd0;
			match_fail_q     <= 1'b0;
			phase_q          <= PH_SKIP;
			negative_q       <= 1'b0;
			line_value_q     <= 32'd0;
			length_q         <= 32'd0;
			hdr_done_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				default_length_q <= cfg_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
			if (advance_s1) begin
				in_value_q   <= in_value_n;
				prev_cr_q    <= prev_cr_n;
				line_start_q <= line_start_n;
				match_pos_q  <= match_pos_n;
				match_fail_q <= match_fail_n;
				phase_q      <= phase_n;
				negative_q   <= negative_n;
				line_value_q <= line_value_n;
				length_q     <= length_n;
				hdr_done_q   <= hdr_done_n;
			end
		end
	end

	// Payload registers: hold while stalled
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
		if (advance_s1) begin
			out_s2 <= result;
		end
	end

`ifndef ASSERT_OFF
	a_hend_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.header_end |->
			out_data.line_done && (out_data.byte_role == ROLE_LF))
		else $error("header_end without a line-ending LF");

	a_ignored_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.byte_role == ROLE_IGNORED) |->
			!out_data.line_done && !out_data.header_end)
		else $error("flags set on an ignored byte");

	a_done_idle_line: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_done_q |-> !in_value_q && (line_start_q == LS_START) && !prev_cr_q)
		else $error("line state active after headers ended");
`endif

endmodule

`default_nettype wire

// ===== bench/hhlp_length_check.sv =====
// Channel monitor for the header length parser: predicts every result word and compares it.
`timescale 1ns / 1ps

module hhlp_length_check (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  hhlp_pkg::hhlp_in_t   in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  hhlp_pkg::hhlp_out_t  out_data,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [30:0]          cfg_data,
	output int                   fault_count,
	output int                   pending
);
	import hhlp_pkg::*;

	localparam int                       FIELD_CHARS  = 14;
	localparam logic [8*FIELD_CHARS-1:0] LENGTH_FIELD = "Content-Length";
	localparam logic [31:0]              MAG_CAP      = 32'h8000_0000;
	localparam logic [31:0]              POS_MAX      = 32'h7fff_ffff;
	localparam int                       PRINT_CAP    = 100;

	// parse state mirrored from the block
	logic        in_val;
	logic        prev_cr;
	line_state_t line_st;
	logic [3:0]  match_pos;
	logic        match_bad;
	phase_t      num_phase;
	logic        num_neg;
	logic [31:0] magnitude;
	logic [31:0] kept_length;
	logic        hdr_done;
	logic [30:0] default_len;

	hhlp_out_t   words_due[$];
	int          words_seen;

	task automatic log_fault(input string what);
		if (fault_count < PRINT_CAP)
			$display("mismatch at %0t, result word %0d: %s", $time, words_seen, what);
		fault_count++;
	endtask

	function automatic void drop_line();
		in_val    = 1'b0;
		line_st   = LS_START;
		match_pos = '0;
		match_bad = 1'b0;
		num_phase = PH_SKIP;
		num_neg   = 1'b0;
		magnitude = '0;
	endfunction

	function automatic void drop_all();
		drop_line();
		prev_cr     = 1'b0;
		kept_length = '0;
		hdr_done    = 1'b0;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
	endfunction

	function automatic void take_digit(input logic [7:0] b);
		logic [63:0] v;
		v = 64'(magnitude) * 64'd10 + (64'(b) - 64'(CHAR_ZERO));
		if (v > 64'(MAG_CAP))
			v = 64'(MAG_CAP);
		magnitude = v[31:0];
		num_phase = PH_DIGITS;
	endfunction

	// atoi-style scan of the value part
	function automatic void scan_value(input logic [7:0] b);
		logic digit;
		digit = b >= CHAR_ZERO && b <= CHAR_NINE;
		case (num_phase)
			PH_SKIP: begin
				if (is_space(b)) begin
				end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
					num_neg   = (b == CHAR_MINUS);
					num_phase = PH_SIGN;
				end else if (digit) begin
					take_digit(b);
				end else begin
					num_phase = PH_DONE;
				end
			end
			PH_SIGN, PH_DIGITS: begin
				if (digit)
					take_digit(b);
				else
					num_phase = PH_DONE;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [31:0] line_number();
		if (!in_val)
			return '0;
		if (num_neg)
			return 32'd0 - magnitude;
		return (magnitude > POS_MAX) ? POS_MAX : magnitude;
	endfunction

	// advance the mirrored state by one byte and form the word it should produce
	function automatic hhlp_out_t fold_byte(input logic [7:0] b, input logic fresh);
		hhlp_out_t r;
		logic      empty_name;
		r = '0;
		if (fresh)
			drop_all();
		if (hdr_done) begin
			r.byte_role = ROLE_IGNORED;
		end else if (b == CHAR_LF && prev_cr) begin
			empty_name  = in_val ? (line_st == LS_COLON_FIRST) : (line_st == LS_CR_ONLY);
			r.byte_role = ROLE_LF;
			r.line_done = 1'b1;
			if (empty_name) begin
				hdr_done     = 1'b1;
				r.header_end = 1'b1;
			end else if (!match_bad && match_pos == FIELD_CHARS) begin
				kept_length = line_number();
			end
			drop_line();
			prev_cr = 1'b0;
		end else if (!in_val) begin
			if (prev_cr)
				match_bad = 1'b1;
			if (line_st == LS_CR_ONLY)
				line_st = LS_NAME;
			if (b == CHAR_COLON) begin
				r.byte_role = ROLE_COLON;
				in_val      = 1'b1;
				line_st     = (line_st == LS_START) ? LS_COLON_FIRST : LS_NAME;
			end else begin
				r.byte_role = ROLE_NAME;
				if (line_st == LS_START)
					line_st = (b == CHAR_CR) ? LS_CR_ONLY : LS_NAME;
				if (b != CHAR_CR) begin
					if (!match_bad && match_pos < FIELD_CHARS &&
					    b == LENGTH_FIELD[8*(FIELD_CHARS-1-match_pos) +: 8])
						match_pos++;
					else
						match_bad = 1'b1;
				end
			end
			prev_cr = (b == CHAR_CR);
		end else begin
			r.byte_role = ROLE_VALUE;
			scan_value(b);
			prev_cr = (b == CHAR_CR);
		end
		r.content_length = (kept_length == '0) ? {1'b0, default_len} : kept_length;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hhlp_out_t want;
		if (!arst_n) begin
			drop_all();
			default_len = DEFAULT_LENGTH;
			words_due.delete();
			words_seen  = 0;
			fault_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (words_due.size() == 0) begin
					log_fault("result word with nothing outstanding");
				end else begin
					want = words_due.pop_front();
					if (out_data.byte_role !== want.byte_role)
						log_fault($sformatf("byte_role %0d, predicted %0d",
							out_data.byte_role, want.byte_role));
					if (out_data.line_done !== want.line_done)
						log_fault($sformatf("line_done %0b, predicted %0b",
							out_data.line_done, want.line_done));
					if (out_data.header_end !== want.header_end)
						log_fault($sformatf("header_end %0b, predicted %0b",
							out_data.header_end, want.header_end));
					if (out_data.content_length !== want.content_length)
						log_fault($sformatf("content_length %0d, predicted %0d",
							out_data.content_length, want.content_length));
				end
				words_seen++;
			end
			if (cfg_valid && cfg_ready)
				default_len = cfg_data;
			if (in_valid && in_ready)
				words_due.push_back(fold_byte(in_data.data_byte, in_data.new_message));
		end
		pending = words_due.size();
	end

endmodule

// ===== bench/http_header_length_parser_unit_tb.sv =====
// Top of the header length parser bench: clock, reset, byte streams, stalls and the verdict.
`timescale 1ns / 1ps

module http_header_length_parser_unit_tb;
	import hhlp_pkg::*;

	localparam int          LIMIT_CYCLES = 300000;
	localparam int          RANDOM_WORDS = 650;
	localparam int          PHASES       = 5;
	localparam int          SETTLE       = 6;  // margin after the last result word
	localparam logic [7:0]  CHAR_VT      = 8'h0b;
	localparam logic [7:0]  CHAR_FF      = 8'h0c;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	hhlp_in_t    in_data;
	logic        out_valid;
	logic        out_ready;
	hhlp_out_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [30:0] cfg_data;

	int          fault_count;
	int          pending;

	// sender burst bookkeeping and receiver stall pattern
	int          burst_left;
	int          rx_mode;
	int          rx_left;

	// bytes of the response being assembled
	logic [7:0]  msg_bytes[$];

	http_header_length_parser_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	hhlp_length_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fault_count (fault_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop: a hung handshake or a lost result word ends up here.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: switch between always-ready stretches, light stalls and heavy
	// stalls, each held for a random number of cycles so stalls land on every
	// phase of the parse.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_left <= $urandom_range(30, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Offer one byte word and hold it until accepted. Between bursts, valid
	// may drop for a random gap; inside a burst keep valid high and only swap
	// the payload at the falling edge after the previous acceptance.
	task automatic send_word(input logic [7:0] b, input logic fresh);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= hhlp_in_t'{data_byte: b, new_message: fresh};
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	// Push the assembled response; the first byte starts a fresh message.
	task automatic send_response();
		foreach (msg_bytes[i])
			send_word(msg_bytes[i], i == 0);
	endtask

	// Drop valid and wait until every predicted word has come back, then let
	// the pipeline settle so nothing is still in flight.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write default_length; only called with the block idle.
	task automatic write_default(input logic [30:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_byte(input logic [7:0] b);
		msg_bytes.push_back(b);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_bytes.push_back(s[i]);
	endtask

	task automatic end_line();
		add_byte(CHAR_CR);
		add_byte(CHAR_LF);
	endtask

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 5))
			0:       return CHAR_SPACE;
			1:       return CHAR_TAB;
			2:       return CHAR_VT;
			3:       return CHAR_FF;
			4:       return CHAR_LF;
			default: return CHAR_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_digit();
		return CHAR_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Names that look close to the length field but must not match it.
	function automatic string pick_name();
		case ($urandom_range(0, 4))
			0:       return "Host";
			1:       return "Content-Type";
			2:       return "content-length";
			3:       return "Content-Lengthy";
			default: return "Content-Lengt";
		endcase
	endfunction

	// A Content-Length line: optional whitespace and sign, digits that
	// sometimes run past the 32-bit range, trailing junk now and then. With
	// stray set, a lone CR lands somewhere in the name or value.
	task automatic add_length_line(input logic stray);
		int start;
		start = msg_bytes.size();
		add_text("Content-Length:");
		repeat ($urandom_range(0, 2)) add_byte(pick_space());
		case ($urandom_range(0, 3))
			0:       add_byte(CHAR_PLUS);
			1:       add_byte(CHAR_MINUS);
			default: begin
			end
		endcase
		case ($urandom_range(0, 7))
			0:       add_text("2147483647");
			1:       add_text("2147483648");
			2:       repeat ($urandom_range(10, 14)) add_byte(pick_digit());
			3:       add_byte(CHAR_ZERO);
			default: repeat ($urandom_range(1, 6)) add_byte(pick_digit());
		endcase
		if ($urandom_range(0, 3) == 0)
			add_byte(8'($urandom_range(32, 126)));
		if (stray)
			msg_bytes.insert($urandom_range(start, msg_bytes.size() - 1), CHAR_CR);
		end_line();
	endtask

	// Mostly well-formed responses with random content; the rest is noise,
	// lines without a colon, and messages cut off before the blank line.
	task automatic compose_response();
		int kind;
		msg_bytes.delete();
		if ($urandom_range(0, 3) == 0) begin
			add_text("HTTP/1.1 200 OK");
			end_line();
		end
		repeat ($urandom_range(0, 4)) begin
			kind = $urandom_range(0, 9);
			if (kind <= 4) begin
				add_length_line(1'b0);
			end else if (kind <= 6) begin
				add_text(pick_name());
				add_text(": ");
				repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(32, 126)));
				end_line();
			end else if (kind == 7) begin
				// length field with no colon: value counts as empty
				add_text("Content-Length");
				if ($urandom_range(0, 1) == 0)
					add_text(" 12");
				end_line();
			end else if (kind == 8) begin
				repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
				if ($urandom_range(0, 1) == 0)
					end_line();
			end else begin
				add_length_line(1'b1);
			end
		end
		case ($urandom_range(0, 5))
			0: begin
				// headers never close
			end
			1: begin
				add_byte(CHAR_COLON);
				add_text(" 9");
				end_line();
				repeat ($urandom_range(0, 6)) add_byte(8'($urandom));
			end
			default: begin
				end_line();
				repeat ($urandom_range(0, 6)) add_byte(8'($urandom));
			end
		endcase
	endtask

	initial begin
		int sent;
		logic [30:0] dflt;
		in_valid   = 1'b0;
		in_data    = '0;
		out_ready  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		arst_n     = 1'b0;
		burst_left = 0;
		rx_mode    = 0;
		rx_left    = 0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opener, under the reset default length.
		// LF as the very first byte is a name byte, then the byte extremes,
		// a CR not followed by LF, and a CR LF that closes the line.
		msg_bytes.delete();
		add_byte(CHAR_LF);
		add_byte(8'hff);
		add_byte(8'h00);
		add_byte(CHAR_CR);
		end_line();
		// colon first: empty name closes the headers, the value bytes do not matter
		add_byte(CHAR_COLON);
		add_byte(CHAR_ZERO + 8'd7);
		end_line();
		// past the headers: ignored
		add_text("Z");
		send_response();
		// fresh message: the length field without a colon leaves the default
		msg_bytes.delete();
		add_text("Content-Length");
		end_line();
		send_response();
		drain();

		// Random phases, each under its own default length; extremes first.
		// The byte budget runs across phases so the total stays near the target.
		sent = 0;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       dflt = 31'h7fff_ffff;
				1:       dflt = 31'd0;
				2:       dflt = 31'd1;
				default: dflt = 31'($urandom);
			endcase
			write_default(dflt);
			while (sent < (p + 1) * RANDOM_WORDS / PHASES) begin
				compose_response();
				send_response();
				sent += msg_bytes.size();
			end
			drain();
		end

		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
